FILE: src/cdl_pkg.sv
// Package for the clock discipline loop: word types, codes, state encoding,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package cdl_pkg;

	localparam int unsigned LockCount = 8;
	localparam int unsigned DivSteps  = 25;
	localparam logic [27:0] PpmScale  = 28'd256000000;

	localparam logic [2:0] SrcWire  = 3'd0;
	localparam logic [2:0] SrcPhc   = 3'd1;
	localparam logic [2:0] SrcGraph = 3'd2;
	localparam logic [2:0] SrcBox   = 3'd3;
	localparam logic [2:0] SrcFree  = 3'd4;

	localparam logic [1:0] StUnlocked = 2'd0;
	localparam logic [1:0] StLocking  = 2'd1;
	localparam logic [1:0] StLocked   = 2'd2;
	localparam logic [1:0] StHoldover = 2'd3;

	localparam logic [2:0] RegRole    = 3'd0;
	localparam logic [2:0] RegNominal = 3'd1;
	localparam logic [2:0] RegSane    = 3'd2;
	localparam logic [2:0] RegGain    = 3'd3;
	localparam logic [2:0] RegMaxCorr = 3'd4;
	localparam logic [2:0] RegSlew    = 3'd5;
	localparam logic [2:0] RegWeight  = 3'd6;
	localparam logic [2:0] RegLockThr = 3'd7;

	typedef struct packed {
		logic [4:0]         sources_present;
		logic signed [23:0] measured_offset;
		logic               sample_valid;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         chosen_source;
		logic [1:0]         lock_status;
		logic signed [23:0] applied_correction;
		logic [24:0]        output_period_ns;
		logic               sample_rejected;
		logic               target_clamped;
		logic [15:0]        change_count;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SEL, S_MULG, S_TGT, S_MULA, S_AVG, S_LOCK, S_FIN,
		S_MULN, S_DIVI, S_DIV, S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic sel;
		logic mulg;
		logic tgt;
		logic mula;
		logic avg;
		logic lock;
		logic fin;
		logic muln;
		logic div_init;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic loop_go;
		logic stat_zero;
		logic div_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: src/cdl_ctrl.sv
// Sequencing state machine for the clock discipline loop.
// Depends on cdl_pkg; drives commands to cdl_datapath.
`default_nettype none
module cdl_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire cdl_pkg::sts_t sts,
	output cdl_pkg::cmd_t     cmd
);
	import cdl_pkg::*;

	state_t state_q, state_next;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_SEL;
				end
			end
			S_SEL: begin
				cmd.sel    = 1'b1;
				state_next = S_MULG;
			end
			S_MULG: begin
				// The selection outcome is registered during the select step.
				if (sts.loop_go) begin
					cmd.mulg   = 1'b1;
					state_next = S_TGT;
				end else begin
					state_next = S_FIN;
				end
			end
			S_TGT: begin
				cmd.tgt    = 1'b1;
				state_next = S_MULA;
			end
			S_MULA: begin
				cmd.mula   = 1'b1;
				state_next = S_AVG;
			end
			S_AVG: begin
				cmd.avg    = 1'b1;
				state_next = S_LOCK;
			end
			S_LOCK: begin
				cmd.lock   = 1'b1;
				state_next = S_FIN;
			end
			S_FIN: begin
				cmd.fin    = 1'b1;
				state_next = sts.stat_zero ? S_EMIT : S_MULN;
			end
			S_MULN: begin
				cmd.muln   = 1'b1;
				state_next = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_next   = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_next = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit   = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/cdl_datapath.sv
// Datapath of the clock discipline loop: configuration registers, loop state,
// shared multiplier register, bit-serial period divider. Depends on cdl_pkg.
`default_nettype none
module cdl_datapath #(
	parameter int unsigned LockRuns = cdl_pkg::LockCount
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [23:0]       cfg_data,
	input  wire cdl_pkg::in_word_t in_data,
	output cdl_pkg::out_word_t     out_data,
	input  wire cdl_pkg::cmd_t     cmd,
	output cdl_pkg::sts_t          sts
);
	import cdl_pkg::*;

	logic        role_q;
	logic [23:0] nominal_q;
	logic [22:0] sane_q, maxc_q, slew_q, thr_q;
	logic [15:0] gain_q, weight_q;

	in_word_t           in_q;
	logic [2:0]         src_q, last_src_q;
	logic [1:0]         stat_q, last_stat_q;
	logic signed [23:0] corr_q;
	logic [23:0]        avg_q, mag_q;
	logic               ever_q, loop_q, rej_q, clamp_q;
	logic [7:0]         run_q;
	logic [15:0]        chg_q;
	logic signed [24:0] resid_q;
	logic signed [41:0] prod_q;
	logic [51:0]        num_q;
	logic [29:0]        dvs_q, rem_q;
	logic [24:0]        dvd_q, quo_q;
	logic [4:0]         cnt_q;
	out_word_t          out_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q    <= 1'b0;
			nominal_q <= 24'd1000000;
			sane_q    <= 23'd2560000;
			gain_q    <= 16'd16384;
			maxc_q    <= 23'd128000;
			slew_q    <= 23'd2560;
			weight_q  <= 16'd8192;
			thr_q     <= 23'd1280;
		end else if (cfg_we) begin
			case (cfg_index)
				RegRole:    role_q    <= cfg_data[0];
				RegNominal: nominal_q <= cfg_data;
				RegSane:    sane_q    <= cfg_data[22:0];
				RegGain:    gain_q    <= cfg_data[15:0];
				RegMaxCorr: maxc_q    <= cfg_data[22:0];
				RegSlew:    slew_q    <= cfg_data[22:0];
				RegWeight:  weight_q  <= cfg_data[15:0];
				RegLockThr: thr_q     <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// Reference selection.
	logic [2:0] pick;
	always_comb begin
		if (role_q)
			pick = in_q.sources_present[0] ? SrcWire : SrcFree;
		else if (in_q.sources_present[1])
			pick = SrcPhc;
		else if (in_q.sources_present[2])
			pick = SrcGraph;
		else if (in_q.sources_present[3])
			pick = SrcBox;
		else
			pick = SrcFree;
	end

	logic signed [24:0] meas_x, lim_x;
	logic               sane;
	assign meas_x = 25'(in_q.measured_offset);
	assign lim_x  = $signed({2'b00, sane_q});
	assign sane   = (meas_x > -lim_x) && (meas_x < lim_x);

	// Rounded Q16 scale of the product register.
	logic signed [41:0] prod_rnd;
	logic signed [25:0] scaled;
	assign prod_rnd = prod_q + 42'sd32768;
	assign scaled   = 26'(prod_rnd >>> 16);

	// Target clamp and slew limit.
	logic signed [27:0] target, maxc_x, step, slew_x;
	logic               tgt_hi, tgt_lo;
	logic signed [27:0] target_c, step_c, corr_new;
	assign target = 28'(corr_q) + 28'(scaled);
	assign maxc_x = $signed({5'b0, maxc_q});
	assign slew_x = $signed({5'b0, slew_q});
	assign tgt_hi = target > maxc_x;
	assign tgt_lo = target < -maxc_x;
	always_comb begin
		target_c = tgt_hi ? maxc_x : (tgt_lo ? -maxc_x : target);
		step     = target_c - 28'(corr_q);
		if (step > slew_x)
			step_c = slew_x;
		else if (step < -slew_x)
			step_c = -slew_x;
		else
			step_c = step;
		corr_new = 28'(corr_q) + step_c;
	end

	logic signed [24:0] resid_abs, diff;
	assign resid_abs = resid_q[24] ? -resid_q : resid_q;
	assign diff      = $signed({1'b0, mag_q}) - $signed({1'b0, avg_q});

	logic [7:0] run_nxt;
	always_comb begin
		if (avg_q < {1'b0, thr_q})
			run_nxt = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
		else
			run_nxt = '0;
	end

	// Divider operands.
	logic [28:0] den;
	logic [53:0] dividend;
	logic [30:0] trial;
	logic        fits;
	assign den      = 29'(PpmScale) + 29'(corr_q);
	assign dividend = {1'b0, num_q, 1'b0} + 54'(den);
	assign trial    = {rem_q, dvd_q[24]};
	assign fits     = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= SrcFree;
			stat_q  <= StUnlocked;
			corr_q  <= '0;
			avg_q   <= '0;
			ever_q  <= 1'b0;
			run_q   <= '0;
			chg_q   <= '0;
			loop_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cmd.sel) begin
				src_q <= pick;
				if (pick != src_q)
					run_q <= '0;
				loop_q <= 1'b0;
				if (pick == SrcFree) begin
					stat_q <= ever_q ? StHoldover : StUnlocked;
				end else if (in_q.sample_valid && sane) begin
					loop_q <= 1'b1;
				end else if (stat_q == StUnlocked || stat_q == StHoldover) begin
					stat_q <= StLocking;
				end
			end
			if (cmd.tgt)
				corr_q <= corr_new[23:0];
			if (cmd.avg) begin
				avg_q  <= ever_q ? avg_q + scaled[23:0] : mag_q;
				ever_q <= 1'b1;
			end
			if (cmd.lock) begin
				run_q  <= run_nxt;
				stat_q <= (run_nxt >= 8'(LockRuns)) ? StLocked : StLocking;
			end
			if (cmd.fin && (src_q != last_src_q || stat_q != last_stat_q))
				chg_q <= chg_q + 16'd1;
			if (cmd.div_init)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 5'd1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load)
			in_q <= in_data;
		if (cmd.sel) begin
			last_src_q  <= src_q;
			last_stat_q <= stat_q;
			clamp_q     <= 1'b0;
			rej_q       <= (pick != SrcFree) && in_q.sample_valid && !sane;
			resid_q     <= meas_x - 25'(corr_q);
		end
		if (cmd.mulg)
			prod_q <= $signed({1'b0, gain_q}) * resid_q;
		if (cmd.tgt) begin
			clamp_q <= tgt_hi || tgt_lo;
			mag_q   <= resid_abs[23:0];
		end
		if (cmd.mula)
			prod_q <= $signed({1'b0, weight_q}) * diff;
		if (cmd.muln)
			num_q <= nominal_q * PpmScale;
		if (cmd.div_init) begin
			dvs_q <= {den, 1'b0};
			rem_q <= {1'b0, dividend[53:25]};
			dvd_q <= dividend[24:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? 30'(trial - {1'b0, dvs_q}) : trial[29:0];
			dvd_q <= {dvd_q[23:0], 1'b0};
			quo_q <= {quo_q[23:0], fits};
		end
		if (cmd.emit) begin
			out_q.chosen_source      <= src_q;
			out_q.lock_status        <= stat_q;
			out_q.applied_correction <= corr_q;
			out_q.output_period_ns   <= (stat_q == StUnlocked) ? {1'b0, nominal_q} : quo_q;
			out_q.sample_rejected    <= rej_q;
			out_q.target_clamped     <= clamp_q;
			out_q.change_count       <= chg_q;
		end
	end

	assign out_data      = out_q;
	assign sts.loop_go   = loop_q;
	assign sts.stat_zero = (stat_q == StUnlocked);
	assign sts.div_last  = (cnt_q == 5'(DivSteps - 1));
endmodule
`default_nettype wire

FILE: src/clock_discipline_loop_top.sv
// After acceptance a word is selected; with a loop update it then passes the gain
// product, target, average product, average and lock steps before the finish step.
// A word that ends unlocked is emitted from there; any other first passes the period
// divider (product, setup and 25 restoring steps). Emission waits while an older result
// is still held. One word at a time: the next is taken once the result is registered.
// Reset: arst_n clears all loop state and restores register defaults at once.
// Top level; depends on cdl_pkg, cdl_ctrl and cdl_datapath.
`default_nettype none
module clock_discipline_loop_top #(
	parameter int unsigned LockRuns = cdl_pkg::LockCount
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cdl_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cdl_pkg::out_word_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);
	import cdl_pkg::*;

	// The controller steps one word through selection, the proportional loop,
	// the residual average, lock tracking and the period division, as each word needs them.
	// The result sits in an output register, so a new word is taken while it waits.
	cmd_t cmd;
	sts_t sts;

	cdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration, the loop state and the divider.
	cdl_datapath #(
		.LockRuns (LockRuns)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
`default_nettype wire
